// File: hdl/keyframe_playhead_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Keyframe playhead interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PLAYHEAD_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_PLAYHEAD_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kpi_pkg.sv
// ----------------------------------------------------------------------------
// kpi_pkg
// Types, widths and codes shared by the keyframe playhead interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

  localparam int MAX_KEYS_DEFAULT = 128;

  localparam int TIME_W  = 24;
  localparam int COORD_W = 16;
  localparam int DT_W    = 16;
  localparam int REQ_W   = 3;
  localparam int TOTAL_W = 8;
  localparam int QUO_W   = COORD_W;
  localparam int PROD_W  = COORD_W + TIME_W;
  localparam int DVD_W   = PROD_W + 2;
  localparam int REM_W   = TIME_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_TOGGLE  = 3'd2,
    REQ_RESTART = 3'd3,
    REQ_SCRUB   = 3'd4
  } kpi_req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } kpi_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [TIME_W-1:0]         key_time;
    logic signed [COORD_W-1:0] key_x;
    logic signed [COORD_W-1:0] key_y;
    logic [DT_W-1:0]           delta_time;
  } kpi_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [TIME_W-1:0]         play_time;
    logic                      playing;
    logic [TOTAL_W-1:0]        key_total;
    logic                      add_rejected;
  } kpi_rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]         key_time;
    logic signed [COORD_W-1:0] key_x;
    logic signed [COORD_W-1:0] key_y;
  } kpi_key_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic cap;
    logic load_zero;
    logic load_first;
    logic load_last;
    logic mul;
    logic dload;
    logic div_step;
    logic fin;
    logic coord_y;
    logic out_load;
  } kpi_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic hit;
    logic zero_len;
    logic scan_last;
    logic div_last;
  } kpi_sts_t;

endpackage

// File: hdl/kpi_if.sv
// ----------------------------------------------------------------------------
// kpi_req_if / kpi_rsp_if
// Valid/ready channels for requests and position results.
// ----------------------------------------------------------------------------
interface kpi_req_if;
  logic              valid;
  logic              ready;
  kpi_pkg::kpi_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kpi_rsp_if;
  logic              valid;
  logic              ready;
  kpi_pkg::kpi_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/kpi_ram.sv
// ----------------------------------------------------------------------------
// kpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/kpi_ctrl.sv
// ----------------------------------------------------------------------------
// kpi_ctrl
// Sequencer: request update, segment scan, multiply, serial divide, result.
// ----------------------------------------------------------------------------
module kpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  kpi_pkg::kpi_sts_t sts,
  output kpi_pkg::kpi_cmd_t cmd
);

  kpi_pkg::kpi_state_t state, state_next;
  logic coord_y, coord_y_next;
  logic out_valid;

  always_comb begin
    state_next   = state;
    coord_y_next = coord_y;
    unique case (state)
      kpi_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = kpi_pkg::ST_START;
        end
      end
      kpi_pkg::ST_START: begin
        coord_y_next = 1'b0;
        state_next   = sts.count_zero ? kpi_pkg::ST_DONE : kpi_pkg::ST_SCAN;
      end
      kpi_pkg::ST_SCAN: begin
        if (sts.hit) begin
          state_next = sts.zero_len ? kpi_pkg::ST_DONE : kpi_pkg::ST_MUL;
        end else if (sts.scan_last) begin
          state_next = kpi_pkg::ST_DONE;
        end
      end
      kpi_pkg::ST_MUL:   state_next = kpi_pkg::ST_DLOAD;
      kpi_pkg::ST_DLOAD: state_next = kpi_pkg::ST_DIV;
      kpi_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_next = kpi_pkg::ST_FIN;
        end
      end
      kpi_pkg::ST_FIN: begin
        if (coord_y) begin
          state_next = kpi_pkg::ST_DONE;
        end else begin
          coord_y_next = 1'b1;
          state_next   = kpi_pkg::ST_MUL;
        end
      end
      kpi_pkg::ST_DONE: begin
        if (!out_valid || rsp_ready) begin
          state_next = kpi_pkg::ST_IDLE;
        end
      end
      default: state_next = kpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.coord_y = coord_y;
    req_ready   = 1'b0;
    unique case (state)
      kpi_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      kpi_pkg::ST_START: begin
        cmd.load_zero = sts.count_zero;
      end
      kpi_pkg::ST_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.cap        = sts.hit;
        cmd.load_first = sts.hit && sts.zero_len;
        cmd.load_last  = !sts.hit && sts.scan_last;
      end
      kpi_pkg::ST_MUL:   cmd.mul      = 1'b1;
      kpi_pkg::ST_DLOAD: cmd.dload    = 1'b1;
      kpi_pkg::ST_DIV:   cmd.div_step = 1'b1;
      kpi_pkg::ST_FIN:   cmd.fin      = 1'b1;
      kpi_pkg::ST_DONE:  cmd.out_load = !out_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kpi_pkg::ST_IDLE;
      coord_y   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      coord_y <= coord_y_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_valid;

endmodule

// File: hdl/kpi_dpath.sv
// ----------------------------------------------------------------------------
// kpi_dpath
// Playhead state, keyframe RAM, segment scan registers, multiplier,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module kpi_dpath #(
  parameter int MAX_KEYS = kpi_pkg::MAX_KEYS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  kpi_pkg::kpi_cmd_t cmd,
  output kpi_pkg::kpi_sts_t sts,
  input  kpi_pkg::kpi_req_t req_data,
  output kpi_pkg::kpi_rsp_t rsp_data
);

  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int REC_W  = $bits(kpi_pkg::kpi_key_t);
  localparam int DIVC_W = $clog2(kpi_pkg::QUO_W);
  localparam int TW     = kpi_pkg::TIME_W;
  localparam int CW     = kpi_pkg::COORD_W;
  localparam int QW     = kpi_pkg::QUO_W;
  localparam int RW     = kpi_pkg::REM_W;

  // playhead state
  logic [CNT_W-1:0] count, count_next;
  logic [TW-1:0]    ph, ph_next;
  logic [TW-1:0]    end_time, end_next;
  logic             run, run_next;
  logic             rej, rej_next;
  logic             wr_en;
  logic             full;
  logic [TW:0]      tick_sum;

  // scan
  logic [ADDR_W-1:0]      scan_idx;
  logic [ADDR_W-1:0]      raddr;
  logic [REC_W-1:0]       ram_rdata;
  kpi_pkg::kpi_key_t      cur, prev, wrec;

  // segment
  logic signed [CW-1:0] base_x, base_y;
  logic [CW-1:0]        mag_x, mag_y;
  logic                 neg_x, neg_y;
  logic [TW-1:0]        num, den;
  logic signed [CW:0]   dx, dy;

  // multiply / divide
  logic [kpi_pkg::PROD_W-1:0] prod;
  logic [kpi_pkg::DVD_W-1:0]  dividend;
  logic [RW-1:0]              rem;
  logic [QW-1:0]              nlow, quo;
  logic [DIVC_W-1:0]          div_cnt;
  logic [RW:0]                cand, dsr, cand_sub;
  logic                       ge;
  logic [CW-1:0]              mul_a;
  logic [CW-1:0]              step, fin_val;

  logic signed [CW-1:0] res_x, res_y;
  kpi_pkg::kpi_rsp_t    rsp_q;

  assign full     = count == CNT_W'(MAX_KEYS);
  assign tick_sum = {1'b0, ph} + (TW+1)'(req_data.delta_time);

  always_comb begin
    count_next = count;
    ph_next    = ph;
    end_next   = end_time;
    run_next   = run;
    rej_next   = 1'b0;
    wr_en      = 1'b0;
    case (req_data.req_type)
      kpi_pkg::REQ_ADD: begin
        if (full) begin
          rej_next = 1'b1;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          if (req_data.key_time > end_time) begin
            end_next = req_data.key_time;
          end
        end
      end
      kpi_pkg::REQ_TICK: begin
        if (run) begin
          if (tick_sum > {1'b0, end_time}) begin
            ph_next  = end_time;
            run_next = 1'b0;
          end else begin
            ph_next = tick_sum[TW-1:0];
          end
        end
      end
      kpi_pkg::REQ_TOGGLE:  run_next = !run;
      kpi_pkg::REQ_RESTART: ph_next = '0;
      kpi_pkg::REQ_SCRUB: begin
        ph_next  = (req_data.key_time > end_time) ? end_time : req_data.key_time;
        run_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ph       <= '0;
      end_time <= '0;
      run      <= 1'b0;
      rej      <= 1'b0;
    end else if (cmd.accept) begin
      count    <= count_next;
      ph       <= ph_next;
      end_time <= end_next;
      run      <= run_next;
      rej      <= rej_next;
    end
  end

  assign wrec.key_time = req_data.key_time;
  assign wrec.key_x    = req_data.key_x;
  assign wrec.key_y    = req_data.key_y;
  assign raddr         = cmd.scan ? scan_idx + ADDR_W'(1) : '0;

  kpi_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept && wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wrec),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign cur = kpi_pkg::kpi_key_t'(ram_rdata);

  // rdata holds entry scan_idx while scanning; prev holds entry scan_idx-1
  always_ff @(posedge clk) begin
    scan_idx <= raddr;
    if (cmd.scan) begin
      prev <= cur;
    end
  end

  assign sts.count_zero = count == '0;
  assign sts.hit        = (scan_idx != '0) && (ph >= prev.key_time) && (ph <= cur.key_time);
  assign sts.zero_len   = prev.key_time == cur.key_time;
  assign sts.scan_last  = CNT_W'(scan_idx) == count - CNT_W'(1);
  assign sts.div_last   = div_cnt == DIVC_W'(QW - 1);

  assign dx = (CW+1)'(cur.key_x) - (CW+1)'(prev.key_x);
  assign dy = (CW+1)'(cur.key_y) - (CW+1)'(prev.key_y);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      base_x <= prev.key_x;
      base_y <= prev.key_y;
      neg_x  <= dx[CW];
      neg_y  <= dy[CW];
      mag_x  <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      mag_y  <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
      num    <= ph - prev.key_time;
      den    <= cur.key_time - prev.key_time;
    end
  end

  // q = (2*mag*num + den) / (2*den), below 2^QUO_W since num <= den
  assign mul_a    = cmd.coord_y ? mag_y : mag_x;
  assign dividend = {1'b0, prod, 1'b0} + kpi_pkg::DVD_W'(den);
  assign dsr      = {1'b0, den, 1'b0};
  assign cand     = {rem, nlow[QW-1]};
  assign ge       = cand >= dsr;
  assign cand_sub = cand - dsr;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= kpi_pkg::PROD_W'(mul_a) * kpi_pkg::PROD_W'(num);
    end
    if (cmd.dload) begin
      rem     <= dividend[RW+QW-1:QW];
      nlow    <= dividend[QW-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? cand_sub[RW-1:0] : cand[RW-1:0];
      nlow    <= {nlow[QW-2:0], 1'b0};
      quo     <= {quo[QW-2:0], ge};
      div_cnt <= div_cnt + DIVC_W'(1);
    end
  end

  assign step    = (cmd.coord_y ? neg_y : neg_x) ? CW'(-quo) : quo;
  assign fin_val = (cmd.coord_y ? base_y : base_x) + step;

  always_ff @(posedge clk) begin
    if (cmd.load_zero) begin
      res_x <= '0;
      res_y <= '0;
    end else if (cmd.load_first) begin
      res_x <= prev.key_x;
      res_y <= prev.key_y;
    end else if (cmd.load_last) begin
      res_x <= cur.key_x;
      res_y <= cur.key_y;
    end else if (cmd.fin) begin
      if (cmd.coord_y) begin
        res_y <= fin_val;
      end else begin
        res_x <= fin_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_q.pos_x        <= res_x;
      rsp_q.pos_y        <= res_y;
      rsp_q.play_time    <= ph;
      rsp_q.playing      <= run;
      rsp_q.key_total    <= kpi_pkg::TOTAL_W'(count);
      rsp_q.add_rejected <= rej;
    end
  end

  assign rsp_data = rsp_q;

endmodule

// File: hdl/keyframe_playhead_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_playhead_interpolator
// Keyframe table with a playhead; reports the interpolated position per request.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (add keyframe, tick, toggle play, restart, scrub);
//   rsp returns one result per request: position, playhead, run flag,
//   keyframe count and the add-rejected flag. Both are valid/ready channels.
//   One request is worked at a time; req.ready is high only while idle.
//   After the request transfer the sequencer starts, scans the keyframes (one
//   per cycle through the single RAM read port, up to MAX_KEYS, none for an
//   empty table) and, when the hit segment is interpolated, runs two passes of
//   multiply and a 16-step restoring divide, x then y, before the result is
//   loaded. The next request can be taken in the cycle after that load.
//   The result sits in an output register; if rsp stalls, the next request is
//   still taken and worked, and waits at the end until the register frees.
//   Reset clears the table count, playhead, end time and run flag; the
//   keyframe RAM itself is not cleared, entries past the count are never used.
// ----------------------------------------------------------------------------
`include "keyframe_playhead_interpolator_macros.svh"

module keyframe_playhead_interpolator #(
  parameter int MAX_KEYS = kpi_pkg::MAX_KEYS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  kpi_req_if.sink  req,
  kpi_rsp_if.source rsp
);

  kpi_pkg::kpi_cmd_t cmd;
  kpi_pkg::kpi_sts_t sts;
  logic              ready;
  logic              valid;
  kpi_pkg::kpi_rsp_t rsp_data;

  kpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .rsp_valid (valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kpi_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_data (req.data),
    .rsp_data (rsp_data)
  );

  assign req.ready = ready;
  assign rsp.valid = valid;
  assign rsp.data  = rsp_data;

  `KPI_ASSERT_NXT(a_busy_after_transfer, req.valid && req.ready, !req.ready,
    "request taken while previous one still in work")
  `KPI_ASSERT_IMP(a_no_overwrite, cmd.out_load, !rsp.valid || rsp.ready,
    "output register overwritten while result pending")
  `KPI_ASSERT_IMP(a_reject_only_full, rsp.valid && rsp.data.add_rejected,
    rsp.data.key_total == kpi_pkg::TOTAL_W'(MAX_KEYS), "add rejected with table not full")
  `KPI_ASSERT_IMP(a_single_result_load, 1'b1,
    ($onehot0({cmd.load_zero, cmd.load_first, cmd.load_last, cmd.fin})),
    "conflicting result loads")

endmodule

// File: tb/kpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_checker
// Watches the request and result channels of the keyframe playhead
// interpolator. It keeps its own keyframe table, playhead and run flag. For
// every request transfer it computes the expected result, and it compares
// each result transfer field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module kpi_checker
  import kpi_pkg::*;
(
  input logic clk,
  input logic rst,
  kpi_req_if  req_mon,
  kpi_rsp_if  rsp_mon,
  output int  fail_count,
  output int  pending,
  output int  checked,
  output int  lerp_hits,
  output int  flat_hits,
  output int  last_hits,
  output int  empty_hits,
  output int  refused_adds
);

  localparam int TABLE_DEPTH = MAX_KEYS_DEFAULT;

  typedef enum logic [1:0] {
    POS_EMPTY,
    POS_LERP,
    POS_FLAT,
    POS_LAST
  } pos_kind_t;

  logic [TIME_W-1:0]         tbl_time [TABLE_DEPTH];
  logic signed [COORD_W-1:0] tbl_x    [TABLE_DEPTH];
  logic signed [COORD_W-1:0] tbl_y    [TABLE_DEPTH];
  int                        tbl_count;
  logic [TIME_W-1:0]         head;
  logic [TIME_W-1:0]         stop_at;
  logic                      running;
  kpi_rsp_t                  expected_q[$];

  // p1 + round((p2 - p1) * num / den), ties away from zero
  function automatic logic signed [COORD_W-1:0] blend(
    input logic signed [COORD_W-1:0] p1,
    input logic signed [COORD_W-1:0] p2,
    input logic [TIME_W-1:0]         num,
    input logic [TIME_W-1:0]         den
  );
    longint          diff;
    longint unsigned mag;
    longint unsigned quo;
    longint          sum;
    diff = longint'(p2) - longint'(p1);
    mag  = (diff < 0) ? -diff : diff;
    quo  = (mag * 64'(num) * 64'd2 + 64'(den)) / (64'(den) * 64'd2);
    sum  = (diff < 0) ? longint'(p1) - longint'(quo) : longint'(p1) + longint'(quo);
    return sum[COORD_W-1:0];
  endfunction

  function automatic void locate(
    output logic signed [COORD_W-1:0] px,
    output logic signed [COORD_W-1:0] py,
    output pos_kind_t                 kind
  );
    int i;
    px   = '0;
    py   = '0;
    kind = POS_EMPTY;
    if (tbl_count == 0) return;
    for (i = 0; i + 1 < tbl_count; i++) begin
      if (head >= tbl_time[i] && head <= tbl_time[i+1]) begin
        if (tbl_time[i] == tbl_time[i+1]) begin
          px   = tbl_x[i];
          py   = tbl_y[i];
          kind = POS_FLAT;
        end else begin
          px   = blend(tbl_x[i], tbl_x[i+1], head - tbl_time[i],
                       tbl_time[i+1] - tbl_time[i]);
          py   = blend(tbl_y[i], tbl_y[i+1], head - tbl_time[i],
                       tbl_time[i+1] - tbl_time[i]);
          kind = POS_LERP;
        end
        return;
      end
    end
    px   = tbl_x[tbl_count-1];
    py   = tbl_y[tbl_count-1];
    kind = POS_LAST;
  endfunction

  function automatic void predict(input kpi_req_t r);
    kpi_rsp_t          e;
    logic [TIME_W:0]   sum;
    pos_kind_t         kind;
    e = '0;
    case (r.req_type)
      REQ_ADD: begin
        if (tbl_count < TABLE_DEPTH) begin
          tbl_time[tbl_count] = r.key_time;
          tbl_x[tbl_count]    = r.key_x;
          tbl_y[tbl_count]    = r.key_y;
          tbl_count++;
          if (r.key_time > stop_at) stop_at = r.key_time;
        end else begin
          e.add_rejected = 1'b1;
          refused_adds++;
        end
      end
      REQ_TICK: begin
        if (running) begin
          sum = {1'b0, head} + (TIME_W+1)'(r.delta_time);
          if (sum > {1'b0, stop_at}) begin
            head    = stop_at;
            running = 1'b0;
          end else begin
            head = sum[TIME_W-1:0];
          end
        end
      end
      REQ_TOGGLE:  running = ~running;
      REQ_RESTART: head = '0;
      REQ_SCRUB: begin
        head    = (r.key_time > stop_at) ? stop_at : r.key_time;
        running = 1'b0;
      end
      default: ;
    endcase
    locate(e.pos_x, e.pos_y, kind);
    case (kind)
      POS_LERP:  lerp_hits++;
      POS_FLAT:  flat_hits++;
      POS_LAST:  last_hits++;
      default:   empty_hits++;
    endcase
    e.play_time = head;
    e.playing   = running;
    e.key_total = tbl_count[TOTAL_W-1:0];
    expected_q.push_back(e);
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_result(input kpi_rsp_t got);
    kpi_rsp_t want;
    if (expected_q.size() == 0) begin
      $error("position result transfer with nothing outstanding");
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
    check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
    check_field("play_time", 32'(want.play_time), 32'(got.play_time));
    check_field("playing", 32'(want.playing), 32'(got.playing));
    check_field("key_total", 32'(want.key_total), 32'(got.key_total));
    check_field("add_rejected", 32'(want.add_rejected), 32'(got.add_rejected));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tbl_count = 0;
      head      = '0;
      stop_at   = '0;
      running   = 1'b0;
      expected_q.delete();
    end else begin
      // a result can never belong to a request taken on the same edge
      if (rsp_mon.valid && rsp_mon.ready) compare_result(rsp_mon.data);
      if (req_mon.valid && req_mon.ready) predict(req_mon.data);
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyframe playhead interpolator. A directed
// opening covers the empty table, unused codes, a zero-length segment, full
// coordinate swings and end clamping; random requests then build a mostly
// ascending keyframe table up to full and beyond, with random gaps on both
// sides and one long result stall. kpi_checker does all the checking.
// ----------------------------------------------------------------------------
module tb_top;
  import kpi_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  localparam int TABLE_DEPTH  = MAX_KEYS_DEFAULT;
  localparam int RAND_ITEMS   = 650;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 300;
  localparam int WATCHDOG_NS  = 8_000_000;

  logic clk;
  logic rst;

  kpi_req_if req_ch();
  kpi_rsp_if rsp_ch();

  int fail_count;
  int pending;
  int checked;
  int lerp_hits;
  int flat_hits;
  int last_hits;
  int empty_hits;
  int refused_adds;

  bit                send_calm;
  bit                recv_calm;
  bit                long_hold;
  int                sent;
  int                keys_sent;
  logic [TIME_W-1:0] t_base;
  logic [TIME_W-1:0] latest_key;

  keyframe_playhead_interpolator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kpi_checker i_chk (
    .clk          (clk),
    .rst          (rst),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .lerp_hits    (lerp_hits),
    .flat_hits    (flat_hits),
    .last_hits    (last_hits),
    .empty_hits   (empty_hits),
    .refused_adds (refused_adds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("keyframe_playhead_interpolator verification failed");
    $finish;
  end

  task automatic send_req(input logic [REQ_W-1:0]         code,
                          input logic [TIME_W-1:0]        t,
                          input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y,
                          input logic [DT_W-1:0]          dt);
    kpi_req_t    item;
    int unsigned gap;
    item.req_type   = code;
    item.key_time   = t;
    item.key_x      = x;
    item.key_y      = y;
    item.delta_time = dt;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // mostly ascending times so the segment search runs deep into the table
  task automatic add_key();
    logic [TIME_W-1:0] t;
    logic [TIME_W:0]   next;
    if ($urandom_range(0, 9) == 0) begin
      t = TIME_W'($urandom);
    end else begin
      next = ($urandom_range(0, 7) == 0)
             ? {1'b0, t_base}
             : {1'b0, t_base} + (TIME_W+1)'($urandom_range(1, 18'h3FFFF));
      t_base = (next > 25'hFFFFFF) ? 24'hFFFFFF : next[TIME_W-1:0];
      t = t_base;
    end
    if (keys_sent == TABLE_DEPTH - 1) t = 24'hFFFFFF;
    if (t > latest_key) latest_key = t;
    send_req(REQ_ADD, t, pick_coord(), pick_coord(), DT_W'($urandom));
    keys_sent++;
  endtask

  initial begin
    int unsigned pause;
    int          taken;
    rsp_ch.ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        pause     = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        pause = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (pause != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
      if (taken % 30 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int                n;
    int unsigned       r;
    int                waited;
    logic [DT_W-1:0]   dt;
    logic [TIME_W-1:0] target;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    send_calm  = 1'b0;
    recv_calm  = 1'b0;
    long_hold  = 1'b0;
    sent       = 0;
    keys_sent  = 0;
    latest_key = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: ticks, play toggles, clamped scrub, unused codes
    send_req(REQ_TICK, 24'h0, 16'sh0, 16'sh0, 16'hFFFF);
    send_req(REQ_TOGGLE, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_TICK, 24'h0, 16'sh0, 16'sh0, 16'hFFFF);
    send_req(REQ_TOGGLE, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_TICK, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_SCRUB, 24'hFFFFFF, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_RESTART, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_SPARE5, 24'hFFFFFF, 16'shFFFF, 16'shFFFF, 16'hFFFF);
    send_req(REQ_SPARE6, 24'hFFFFFF, 16'shFFFF, 16'shFFFF, 16'hFFFF);
    send_req(REQ_SPARE7, 24'hFFFFFF, 16'shFFFF, 16'shFFFF, 16'hFFFF);
    // single key, then a zero-length segment at 0, then a full-swing segment
    send_req(REQ_ADD, 24'h0, 16'sh8000, 16'sh7FFF, 16'h0);
    send_req(REQ_ADD, 24'h0, 16'sh7FFF, 16'sh8000, 16'h0);
    send_req(REQ_ADD, 24'h400, 16'sh8000, 16'sh7FFF, 16'h0);
    send_req(REQ_SCRUB, 24'h200, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_SCRUB, 24'h155, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_SCRUB, 24'h1000, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_RESTART, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_TOGGLE, 24'h0, 16'sh0, 16'sh0, 16'h0);
    send_req(REQ_TICK, 24'h0, 16'sh0, 16'sh0, 16'h100);
    send_req(REQ_TICK, 24'h0, 16'sh0, 16'sh0, 16'hFFFF);
    send_req(REQ_RESTART, 24'h0, 16'sh0, 16'sh0, 16'h0);
    // earlier time leaves the end time alone
    send_req(REQ_ADD, 24'h300, 16'sh5, -16'sh5, 16'h0);
    send_req(REQ_SCRUB, 24'h3FF, 16'sh0, 16'sh0, 16'h0);
    keys_sent  = 4;
    t_base     = 24'h400;
    latest_key = 24'h400;

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) long_hold = 1'b1;
      if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if ((keys_sent < TABLE_DEPTH &&
           RAND_ITEMS - n <= TABLE_DEPTH - keys_sent + 30) || r < 20) begin
        add_key();
      end else if (r < 55) begin
        dt = ($urandom_range(0, 6) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                         : DT_W'($urandom);
        send_req(REQ_TICK, TIME_W'($urandom), pick_coord(), pick_coord(), dt);
      end else if (r < 67) begin
        send_req(REQ_TOGGLE, TIME_W'($urandom), pick_coord(), pick_coord(),
                 DT_W'($urandom));
      end else if (r < 87) begin
        target = ($urandom_range(0, 4) == 0) ? TIME_W'($urandom)
                                             : TIME_W'($urandom_range(0, latest_key));
        send_req(REQ_SCRUB, target, pick_coord(), pick_coord(), DT_W'($urandom));
      end else if (r < 95) begin
        send_req(REQ_RESTART, TIME_W'($urandom), pick_coord(), pick_coord(),
                 DT_W'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_req(REQ_SPARE5, TIME_W'($urandom), pick_coord(), pick_coord(),
                            DT_W'($urandom));
          1:       send_req(REQ_SPARE6, TIME_W'($urandom), pick_coord(), pick_coord(),
                            DT_W'($urandom));
          default: send_req(REQ_SPARE7, TIME_W'($urandom), pick_coord(), pick_coord(),
                            DT_W'($urandom));
        endcase
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);

    if (pending != 0) $error("%0d position results never arrived", pending);
    $display("Sent %0d requests, %0d results compared; %0d adds refused on a full table.",
             sent, checked, refused_adds);
    $display("Positions: %0d interpolated, %0d zero-length, %0d after the last segment, %0d empty.",
             lerp_hits, flat_hits, last_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("keyframe_playhead_interpolator verification clean");
    end else begin
      $display("keyframe_playhead_interpolator verification failed");
    end
    $finish;
  end

endmodule
